### design/asi_pkg.sv
// Package for the ascending integer sorter.
// Holds status codes and the command and status structs shared by the
// controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package asi_pkg;

  // Width of a stored element (the sign bit is never stored).
  localparam int VALUE_W = 31;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NEGATIVE = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // an input beat is accepted this cycle
    logic scan;      // one compare-and-shift step of the insertion
    logic place;     // write the held element at slot zero
    logic emit_rd;   // read the next sorted entry
    logic emit_ld;   // move the read entry into the result register
    logic err_ld;    // move an error result into the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_final;   // final flag of the beat on the input channel
    logic err_final;    // that final beat closes a set with an error
    logic start_scan;   // that beat needs an insertion scan
    logic held_final;   // the element under insertion closes its set
    logic greater;      // entry read during the scan is above the element
    logic idx_one;      // the scan has reached slot one
    logic out_free;     // the result register can take a beat
    logic emit_last;    // the entry being emitted is the last of the set
  } status_t;

endpackage

### design/asi_if.sv
// Channel interfaces of the ascending integer sorter: input items and results.
// Depends on asi_pkg for the element width.
`timescale 1ns / 1ps

interface asi_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink (input valid, input value, input final_item, output ready);
endinterface

interface asi_result_if import asi_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sorted_value;
  logic               end_of_run;
  logic [1:0]         status;

  modport source (output valid, output sorted_value, output end_of_run, output status,
                  input ready);
  modport sink (input valid, input sorted_value, input end_of_run, input status,
                output ready);
endinterface

### design/asi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module asi_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/asi_datapath.sv
// Datapath of the ascending integer sorter: sorted store, element count,
// error flags, insertion index, emit pointer and the result register.
// Depends on asi_pkg and asi_ram.
`timescale 1ns / 1ps

module asi_datapath import asi_pkg::*; #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             stat,
  input  logic signed [31:0]  item_value,
  input  logic                item_final,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [VALUE_W-1:0]  result_value,
  output logic                result_end,
  output logic [1:0]          result_status
);

  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

  logic [CNT_W-1:0]   count;
  logic               negative_seen;
  logic               overflow_seen;
  logic [VALUE_W-1:0] held;
  logic               held_final;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  emit_ptr;

  logic               neg_now;
  logic               full;
  logic               ovf_now;
  logic               err_final;
  logic               store_item;
  logic [CNT_W-1:0]   count_m1;
  logic               out_free;
  logic               emit_last;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // Classify the beat on the input channel.
  assign neg_now    = item_value[31];
  assign full       = (count == CNT_W'(MAX_ELEMENTS));
  assign ovf_now    = !neg_now && full;
  assign err_final  = item_final && (neg_now || ovf_now || negative_seen || overflow_seen);
  assign store_item = !neg_now && !full && !err_final;
  assign count_m1   = count - CNT_W'(1);
  assign out_free   = !result_valid || result_ready;
  assign emit_last  = (CNT_W'(emit_ptr) == count_m1);

  always_comb begin
    stat.item_final = item_final;
    stat.err_final  = err_final;
    stat.start_scan = store_item && (count != '0);
    stat.held_final = held_final;
    stat.greater    = (ram_rdata > held);
    stat.idx_one    = (idx == ADDR_W'(1));
    stat.out_free   = out_free;
    stat.emit_last  = emit_last;
  end

  // Store write and read address selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = held;
    ram_raddr = emit_ptr;
    if (cmd.take) begin
      ram_raddr = count_m1[ADDR_W-1:0];
      if (store_item && (count == '0)) begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = item_value[VALUE_W-1:0];
      end
    end else if (cmd.scan) begin
      ram_we    = 1'b1;
      ram_raddr = idx - ADDR_W'(2);
      if (stat.greater) begin
        ram_wdata = ram_rdata;
      end
    end else if (cmd.place) begin
      ram_we = 1'b1;
    end
  end

  asi_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Set bookkeeping: count, error flags, insertion index and emit pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      negative_seen <= 1'b0;
      overflow_seen <= 1'b0;
      held_final    <= 1'b0;
      idx           <= '0;
      emit_ptr      <= '0;
    end else begin
      if (cmd.take) begin
        held       <= item_value[VALUE_W-1:0];
        held_final <= item_final;
        idx        <= count[ADDR_W-1:0];
        if (neg_now) begin
          negative_seen <= 1'b1;
        end
        if (ovf_now) begin
          overflow_seen <= 1'b1;
        end
        if (store_item && (count == '0)) begin
          count <= CNT_W'(1);
        end
      end else if (cmd.scan) begin
        if (stat.greater) begin
          idx <= idx - ADDR_W'(1);
        end else begin
          count <= count + CNT_W'(1);
        end
      end else if (cmd.place) begin
        count <= count + CNT_W'(1);
      end else if (cmd.emit_ld && out_free) begin
        if (emit_last) begin
          count    <= '0;
          emit_ptr <= '0;
        end else begin
          emit_ptr <= emit_ptr + ADDR_W'(1);
        end
      end else if (cmd.err_ld && out_free) begin
        count         <= '0;
        negative_seen <= 1'b0;
        overflow_seen <= 1'b0;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((cmd.emit_ld || cmd.err_ld) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_ld && out_free) begin
      result_value  <= ram_rdata;
      result_end    <= emit_last;
      result_status <= STATUS_OK;
    end else if (cmd.err_ld && out_free) begin
      result_value  <= '0;
      result_end    <= 1'b1;
      result_status <= negative_seen ? STATUS_NEGATIVE : STATUS_OVERFLOW;
    end
  end

endmodule

### design/asi_controller.sv
// Controller of the ascending integer sorter: one-hot state machine that
// sequences loading, insertion, emission and error reporting.
// Depends on asi_pkg.
`timescale 1ns / 1ps

module asi_controller import asi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t stat,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_PLACE   = 6'b000100,
    S_EMIT_RD = 6'b001000,
    S_EMIT_LD = 6'b010000,
    S_ERR     = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  // Commands follow the state directly; take also needs a valid input beat.
  always_comb begin
    cmd.take    = (state == S_IDLE) && item_valid;
    cmd.scan    = (state == S_SCAN);
    cmd.place   = (state == S_PLACE);
    cmd.emit_rd = (state == S_EMIT_RD);
    cmd.emit_ld = (state == S_EMIT_LD);
    cmd.err_ld  = (state == S_ERR);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (stat.err_final) begin
            state_next = S_ERR;
          end else if (stat.start_scan) begin
            state_next = S_SCAN;
          end else if (stat.item_final) begin
            state_next = S_EMIT_RD;
          end
        end
      end
      S_SCAN: begin
        if (stat.greater) begin
          if (stat.idx_one) begin
            state_next = S_PLACE;
          end
        end else begin
          state_next = stat.held_final ? S_EMIT_RD : S_IDLE;
        end
      end
      S_PLACE: begin
        state_next = stat.held_final ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          state_next = stat.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/ascending_integer_sorter.sv
// Insertion: an element walks down past every stored entry above it; an element into an
// empty store, a negative element or a dropped element is taken without a walk. Insertion
// walks the store one entry per cycle through its single read port. After the final
// beat each result goes through a store read, then the result register; an error skips the read.
// Throughput: one set at a time; the next beat is taken once the last result is loaded.
// Reset clears count, flags and control; store contents stay undefined, no clearing pass.
`timescale 1ns / 1ps

module ascending_integer_sorter import asi_pkg::*; #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic         clk,
  input  logic         rst,
  asi_item_if.sink     items,
  asi_result_if.source results
);

  cmd_t    cmd;
  status_t stat;

  asi_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (items.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  asi_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .item_value    (items.value),
    .item_final    (items.final_item),
    .result_valid  (results.valid),
    .result_ready  (results.ready),
    .result_value  (results.sorted_value),
    .result_end    (results.end_of_run),
    .result_status (results.status)
  );

`ifndef NO_ASSERTIONS
  // An error result is a single beat that closes the run with a zero value.
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.status != STATUS_OK)) |->
      (results.end_of_run && (results.sorted_value == '0)))
    else $error("error result is not a lone zero beat");

  // While a run is still being emitted no new input is taken.
  a_no_input_mid_run: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.end_of_run) |-> !items.ready)
    else $error("input accepted in the middle of a run");

  // Commands are mutually exclusive.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.scan, cmd.place, cmd.emit_rd, cmd.emit_ld, cmd.err_ld}))
    else $error("more than one datapath command at once");

  // The result register is only loaded from the emit or error steps.
  a_load_source: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(cmd.emit_ld || cmd.err_ld))
    else $error("result beat appeared without a load command");
`endif

endmodule

### sim/asi_sort_checker.sv
// Checker for the ascending integer sorter: watches the item and result channels,
// predicts every result of a set and compares it field by field.
// Depends on asi_pkg for the element width and the status codes.
`timescale 1ns / 1ps

module asi_sort_checker import asi_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic signed [31:0] item_value,
  input  logic               item_final,
  input  logic               res_valid,
  input  logic               res_ready,
  input  logic [VALUE_W-1:0] res_value,
  input  logic               res_end,
  input  logic [1:0]         res_status,
  output int                 failures,
  output int                 results_left,
  output int                 results_checked
);

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic [1:0]         status;
  } sorted_result_t;

  localparam int FIFO_DEPTH = 256;

  // Model of the block: the sorted store, its fill and the two error flags.
  logic [VALUE_W-1:0] sorted_store [CAPACITY];
  int                 stored_count = 0;
  bit                 negative_flag = 1'b0;
  bit                 overflow_flag = 1'b0;

  // Expected results, oldest first, in a ring with free-running pointers.
  sorted_result_t     expected_fifo [FIFO_DEPTH];
  int                 wr_ptr = 0;
  int                 rd_ptr = 0;
  int                 fail_count = 0;
  int                 checked_count = 0;

  assign failures        = fail_count;
  assign results_checked = checked_count;
  assign results_left    = wr_ptr - rd_ptr;

  function automatic void add_expected(sorted_result_t r);
    expected_fifo[wr_ptr % FIFO_DEPTH] = r;
    wr_ptr++;
  endfunction

  // Insert after every stored entry that is less than or equal to the new one.
  function automatic void place_sorted(logic [VALUE_W-1:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = stored_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (sorted_store[mid] <= v) lo = mid + 1;
      else hi = mid;
    end
    for (int i = stored_count; i > lo; i--) sorted_store[i] = sorted_store[i - 1];
    sorted_store[lo] = v;
    stored_count++;
  endfunction

  // Take one element in; a final element releases the whole set or one error.
  function automatic void predict_beat(logic signed [31:0] v, logic last);
    sorted_result_t r;
    if (v[31]) negative_flag = 1'b1;
    else if (stored_count < CAPACITY) place_sorted(v[VALUE_W-1:0]);
    else overflow_flag = 1'b1;
    if (!last) return;
    if (negative_flag || overflow_flag) begin
      r.value  = '0;
      r.last   = 1'b1;
      r.status = negative_flag ? STATUS_NEGATIVE : STATUS_OVERFLOW;
      add_expected(r);
    end else begin
      for (int k = 0; k < stored_count; k++) begin
        r.value  = sorted_store[k];
        r.last   = (k == stored_count - 1);
        r.status = STATUS_OK;
        add_expected(r);
      end
    end
    stored_count  = 0;
    negative_flag = 1'b0;
    overflow_flag = 1'b0;
  endfunction

  // Both channels are sampled at the rising edge, before any update of that edge.
  always @(posedge clk) begin
    sorted_result_t exp_r;
    if (!rst) begin
      if (item_valid && item_ready) predict_beat(item_value, item_final);
      if (res_valid && res_ready) begin
        checked_count++;
        if (wr_ptr == rd_ptr) begin
          $error("unexpected result beat: sorted_value %0d end_of_run %0b status %0d",
                 res_value, res_end, res_status);
          fail_count++;
        end else begin
          exp_r = expected_fifo[rd_ptr % FIFO_DEPTH];
          rd_ptr++;
          if (res_value !== exp_r.value) begin
            $error("sorted_value mismatch: expected %0d, actual %0d", exp_r.value, res_value);
            fail_count++;
          end
          if (res_end !== exp_r.last) begin
            $error("end_of_run mismatch: expected %0b, actual %0b", exp_r.last, res_end);
            fail_count++;
          end
          if (res_status !== exp_r.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_r.status, res_status);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### sim/tb.sv
// Testbench top for the ascending integer sorter: clock, reset, item stimulus,
// result back-pressure and the verdict. Depends on asi_pkg, the channel
// interfaces, the sorter itself and asi_sort_checker.
`timescale 1ns / 1ps

module tb;
  import asi_pkg::*;

  localparam int CAPACITY = 64;

  logic clk = 1'b0;
  logic rst;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent  = 0;
  int sets_sent   = 0;
  int failures;
  int results_left;
  int results_checked;

  asi_item_if   item_ch ();
  asi_result_if result_ch ();

  ascending_integer_sorter #(.MAX_ELEMENTS(CAPACITY)) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch)
  );

  asi_sort_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_ch.valid),
    .item_ready      (item_ch.ready),
    .item_value      (item_ch.value),
    .item_final      (item_ch.final_item),
    .res_valid       (result_ch.valid),
    .res_ready       (result_ch.ready),
    .res_value       (result_ch.sorted_value),
    .res_end         (result_ch.end_of_run),
    .res_status      (result_ch.status),
    .failures        (failures),
    .results_left    (results_left),
    .results_checked (results_checked)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result back-pressure: ready drops at random at the current idle rate.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // Non-negative element, weighted toward the extremes and small duplicates.
  function automatic logic signed [31:0] pick_element();
    case ($urandom_range(9))
      0: return 32'sd0;
      1: return 32'sh7FFF_FFFF;
      2, 3, 4: return $urandom_range(15);
      default: return {1'b0, 31'($urandom)};
    endcase
  endfunction

  function automatic logic signed [31:0] pick_negative();
    return {1'b1, 31'($urandom)};
  endfunction

  // Present one beat and hold it until it is taken; valid stays high into the next beat.
  task automatic send_item(input logic signed [31:0] v, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.value      <= v;
    item_ch.final_item <= last;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    if (last) sets_sent++;
  endtask

  // One set of the given size; a negative element goes at neg_pos unless it is -1.
  task automatic send_set(input int size, input int neg_pos);
    for (int i = 0; i < size; i++)
      send_item((i == neg_pos) ? pick_negative() : pick_element(), i == size - 1);
  endtask

  task automatic send_small_sets(input int item_goal);
    int size;
    int start;
    start = items_sent;
    while (items_sent - start < item_goal) begin
      size = ($urandom_range(3) == 0) ? $urandom_range(10, 4) : $urandom_range(3, 1);
      send_set(size, ($urandom_range(9) == 0) ? int'($urandom_range(size - 1)) : -1);
    end
  endtask

  initial begin
    int waited;
    int leftover;
    leftover = 0;
    rst <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.value      <= '0;
    item_ch.final_item <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 7;  rx_idle_pct = 49; end
        1: begin tx_idle_pct = 49; rx_idle_pct = 7;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase

      if (phase == 0) begin
        // Single element, and the smallest value.
        send_item(32'sd0, 1'b1);
        // Extremes, duplicates and a descending start.
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(32'sd5, 1'b1);
        // Already ascending.
        send_item(32'sd1, 1'b0);
        send_item(32'sd2, 1'b0);
        send_item(32'sd3, 1'b1);
        // Negative element in the middle of a set, the most negative value.
        send_item(32'sd7, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sd9, 1'b1);
        // Negative final element, alone and after a good one.
        send_item(-32'sd1, 1'b1);
        send_item(32'sd4, 1'b0);
        send_item(-32'sd1, 1'b1);
        // Alternating bit patterns.
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'sh2AAA_AAAA, 1'b1);
      end

      send_small_sets(25);
      // One large set per phase: overflow, exactly full, then overflow with a negative.
      case (phase)
        0: send_set(CAPACITY + 1 + $urandom_range(1), -1);
        1: send_set(CAPACITY, -1);
        default: send_set(CAPACITY + 2, $urandom_range(CAPACITY + 1));
      endcase
      send_small_sets(30);
    end
    item_ch.valid <= 1'b0;

    // Let the checker see the last beat, drain the outstanding results,
    // then watch for stray beats.
    @(posedge clk);
    waited = 0;
    while (results_left != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (results_left != 0) begin
      $error("%0d expected results never arrived", results_left);
      leftover = results_left;
    end

    $display("Sent %0d items in %0d sets and checked %0d results,", items_sent, sets_sent,
             results_checked);
    $display("covering full, overflowing and negative sets under three stall patterns.");
    if (failures == 0 && leftover == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
